/* sv/csw_pkg.sv */
// Shared types and constants for the counting semaphore with a waiter queue.
// Holds the command and response beat structs, operation and status codes.
// No dependencies.
`default_nettype none

package csw_pkg;

  localparam int MAX_WAITERS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int TASK_W      = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_LIMIT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COUNT = 1'd1;

  localparam logic [1:0] OP_TAKE   = 2'd0;
  localparam logic [1:0] OP_GIVE   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_REFUSED   = 3'd1;
  localparam logic [2:0] ST_PENDED    = 3'd2;
  localparam logic [2:0] ST_WOKEN     = 3'd3;
  localparam logic [2:0] ST_RAISED    = 3'd4;
  localparam logic [2:0] ST_AT_LIMIT  = 3'd5;
  localparam logic [2:0] ST_CANCELLED = 3'd6;
  localparam logic [2:0] ST_IGNORED   = 3'd7;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TASK_W-1:0] task_id;
    logic              no_wait;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [TASK_W-1:0] woken_task;
    logic [15:0]       count_now;
    logic [4:0]        waiters_now;
  } rsp_t;

endpackage

`default_nettype wire

/* sv/csw_ram.sv */
// Simple dual-port memory for the waiter id queue, one write and one read port.
// Read data is registered, so it appears in the cycle after a read with rd_en high.
// No dependencies.
`default_nettype none

module csw_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/counting_semaphore_with_waiters_unit.sv */
// A take, a refused give and a count raise go from accept to S_EMIT, which
// registers the response; a give that wakes a waiter passes S_WAKE first; a
// cancel with waiters queued scans the entries in S_SCAN and moves the entries
// behind the match up in S_SHIFT. One command is in flight at a time; the next
// command waits until S_EMIT, which a stalled response holds, registers the last.
// Reset empties the queue, loads the count with 0 and the limit with all ones.
// Depends on csw_pkg and csw_ram.
`default_nettype none

module counting_semaphore_with_waiters_unit #(
  parameter int MAX_WAITERS = csw_pkg::MAX_WAITERS_DEF,
  parameter int COUNT_BITS  = csw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_stall,
  input  wire csw_pkg::cmd_t                   cmd,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output csw_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [csw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [csw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int OCC_W = $clog2(MAX_WAITERS + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(MAX_WAITERS);
  localparam logic [OCC_W:0]   DEPTH_X  = (OCC_W + 1)'(MAX_WAITERS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAKE,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [IDX_W-1:0]             head;
  logic [OCC_W-1:0]             occ;
  logic [OCC_W-1:0]             pos;
  logic [COUNT_BITS-1:0]        count;
  logic [COUNT_BITS-1:0]        limit;
  logic [csw_pkg::TASK_W-1:0]   tid;
  logic [2:0]                   status_q;
  logic [csw_pkg::TASK_W-1:0]   woken_q;

  logic                         accept;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [csw_pkg::TASK_W-1:0]   wr_data;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [csw_pkg::TASK_W-1:0]   rd_data;
  logic [OCC_W:0]               occ_x;
  logic [OCC_W:0]               pos1;
  logic [OCC_W:0]               pos2;
  logic                         more1;
  logic                         more2;
  logic [COUNT_BITS+15:0]       cfg_x;
  logic [COUNT_BITS+15:0]       cnt_x;
  logic [OCC_W+4:0]             occ_w;

  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [OCC_W:0]   ofs);
    logic [OCC_W:0] sum;
    sum = {{(OCC_W + 1 - IDX_W){1'b0}}, base} + ofs;
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = cmd_valid && (state == S_IDLE);

  assign occ_x = {1'b0, occ};
  assign pos1  = {1'b0, pos} + (OCC_W + 1)'(1);
  assign pos2  = {1'b0, pos} + (OCC_W + 1)'(2);
  assign more1 = (pos1 < occ_x);
  assign more2 = (pos2 < occ_x);
  assign cfg_x = {{COUNT_BITS{1'b0}}, cfg_data};
  assign cnt_x = {16'd0, count};
  assign occ_w = {5'd0, occ};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wrap_add(head, occ_x);
    wr_data = cmd.task_id;
    rd_en   = 1'b0;
    rd_addr = head;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.operation == csw_pkg::OP_TAKE && count == '0 && !cmd.no_wait &&
              occ != OCC_FULL) begin
            wr_en = 1'b1;
          end
          if ((cmd.operation == csw_pkg::OP_GIVE || cmd.operation == csw_pkg::OP_CANCEL) &&
              occ != '0) begin
            rd_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        rd_en   = more1;
        rd_addr = wrap_add(head, pos1);
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(head, {1'b0, pos});
        wr_data = rd_data;
        rd_en   = more2;
        rd_addr = wrap_add(head, pos2);
      end
      default: begin
      end
    endcase
  end

  csw_ram #(
    .DEPTH  (MAX_WAITERS),
    .ADDR_W (IDX_W),
    .DATA_W (csw_pkg::TASK_W)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      pos       <= '0;
      count     <= '0;
      limit     <= '1;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == csw_pkg::CFG_COUNT_LIMIT) begin
          limit <= cfg_x[COUNT_BITS-1:0];
        end else if (cfg_index == csw_pkg::CFG_INITIAL_COUNT) begin
          count <= cfg_x[COUNT_BITS-1:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tid      <= cmd.task_id;
            woken_q  <= '0;
            pos      <= '0;
            status_q <= csw_pkg::ST_REFUSED;
            state    <= S_EMIT;
            case (cmd.operation)
              csw_pkg::OP_TAKE: begin
                if (count != '0) begin
                  count    <= count - COUNT_BITS'(1);
                  status_q <= csw_pkg::ST_GRANTED;
                end else if (!cmd.no_wait && occ != OCC_FULL) begin
                  occ      <= occ + OCC_W'(1);
                  status_q <= csw_pkg::ST_PENDED;
                end
              end
              csw_pkg::OP_GIVE: begin
                if (occ != '0) begin
                  state <= S_WAKE;
                end else if (count < limit) begin
                  count    <= count + COUNT_BITS'(1);
                  status_q <= csw_pkg::ST_RAISED;
                end else begin
                  status_q <= csw_pkg::ST_AT_LIMIT;
                end
              end
              csw_pkg::OP_CANCEL: begin
                status_q <= csw_pkg::ST_IGNORED;
                if (occ != '0) begin
                  state <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WAKE: begin
          woken_q  <= rd_data;
          head     <= wrap_add(head, (OCC_W + 1)'(1));
          occ      <= occ - OCC_W'(1);
          status_q <= csw_pkg::ST_WOKEN;
          state    <= S_EMIT;
        end
        S_SCAN: begin
          if (rd_data == tid) begin
            status_q <= csw_pkg::ST_CANCELLED;
            if (more1) begin
              state <= S_SHIFT;
            end else begin
              occ   <= occ - OCC_W'(1);
              state <= S_EMIT;
            end
          end else if (more1) begin
            pos <= pos1[OCC_W-1:0];
          end else begin
            state <= S_EMIT;
          end
        end
        S_SHIFT: begin
          pos <= pos1[OCC_W-1:0];
          if (!more2) begin
            occ   <= occ - OCC_W'(1);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= status_q;
            rsp.woken_task  <= woken_q;
            rsp.count_now   <= cnt_x[15:0];
            rsp.waiters_now <= occ_w[4:0];
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
